// ----- design/assert_macros.svh -----
// Assertion macros for the design files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while the given reset is high.
`define USV_ASSERT_ON(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion on the block clock clk, disabled during reset rst.
`define USV_ASSERT(label, prop, msg) \
  `USV_ASSERT_ON(label, clk, rst, prop, msg)

`endif

// ----- design/usv_pkg.sv -----
// Types and constants shared by the UTF-8 stream validator files.
package usv_pkg;

  // Byte classification masks and patterns.
  localparam logic [7:0] AsciiMax       = 8'h7f;
  localparam logic [7:0] ContMask       = 8'hc0;
  localparam logic [7:0] ContPattern    = 8'h80;
  localparam logic [7:0] Lead2Pattern   = 8'hc0;
  localparam logic [7:0] Lead3Mask      = 8'he0;
  localparam logic [7:0] Lead3Pattern   = 8'he0;
  localparam logic [7:0] Lead4Mask      = 8'hf0;
  localparam logic [7:0] Lead4Pattern   = 8'hf0;
  localparam logic [7:0] Lead4TestMask  = 8'hf8;
  localparam logic [7:0] SurrogateLead  = 8'hed;
  localparam logic [7:0] SurrogateMask  = 8'ha0;

  // Continuation counts owed by each lead form.
  localparam logic [1:0] OweNone = 2'd0;
  localparam logic [1:0] OweOne  = 2'd1;
  localparam logic [1:0] OweTwo  = 2'd2;
  localparam logic [1:0] OweThree = 2'd3;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_item_t;

  // One result item.
  typedef struct packed {
    logic valid_res;
    logic final_res;
  } result_item_t;

  // Per-message decoder state.
  typedef struct packed {
    logic [1:0] owed;
    logic       surrogate_check;
    logic       error_seen;
  } check_state_t;

  // Pipeline control between the input register and the result register.
  typedef struct packed {
    logic item_valid;
    logic advance;
  } stage_ctrl_t;

endpackage

// ----- design/usv_byte_if.sv -----
// Stream interface that carries message bytes into the validator.
interface usv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ----- design/usv_result_if.sv -----
// Stream interface that carries validation results out of the validator.
interface usv_result_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic final_res;

  modport source (output valid, output valid_res, output final_res, input ready);
  modport sink (input valid, input valid_res, input final_res, output ready);
endinterface

// ----- design/utf8_stream_validator_unit.sv -----
// Top level of the UTF-8 stream validator.
//
// byte_stream takes a message one byte item at a time, with end_of_message
// set on its last byte. result_stream gives one item for every byte:
// valid_res is 1 while no error has been seen in the message, and on the
// last byte (final_res = 1) it is the verdict for the whole message.
// From acceptance, the byte waits in the input register, then its result is
// loaded into the result register and offered there. Throughput is one byte
// per cycle while result_stream does not stall, set by the combinational check
// between the two registers, with the decoder state updated as each item
// enters the result register.
// When result_stream stalls, the result register holds its item and the
// input register keeps its byte, or takes one more byte if it was empty;
// byte_stream.ready then drops until the stalled result is taken.
// A synchronous reset on rst empties both registers and clears the decoder
// state, so the next byte starts a new message.
`include "assert_macros.svh"

module utf8_stream_validator_unit (
  input  logic         clk,
  input  logic         rst,
  usv_byte_if.sink     byte_stream,
  usv_result_if.source result_stream
);
  import usv_pkg::*;

  byte_item_t   in_item;
  byte_item_t   item;
  logic         item_valid;
  logic         space;
  stage_ctrl_t  ctrl;
  result_item_t result;
  result_item_t out_item;
  check_state_t state;

  assign in_item.data_byte      = byte_stream.data_byte;
  assign in_item.end_of_message = byte_stream.end_of_message;

  // An item moves on when it is present and the result register has space.
  assign ctrl.item_valid = item_valid;
  assign ctrl.advance    = item_valid && space;

  usv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (byte_stream.valid),
    .in_ready   (byte_stream.ready),
    .in_item    (in_item),
    .advance    (ctrl.advance),
    .item_valid (item_valid),
    .item       (item)
  );

  usv_checker u_checker (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .item   (item),
    .result (result),
    .state  (state)
  );

  usv_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .result    (result),
    .space     (space),
    .out_valid (result_stream.valid),
    .out_ready (result_stream.ready),
    .out_item  (out_item)
  );

  assign result_stream.valid_res = out_item.valid_res;
  assign result_stream.final_res = out_item.final_res;

  // The surrogate check is only pending right after lead 0xED.
  `USV_ASSERT(a_surrogate_state, state.surrogate_check |-> (state.owed == OweTwo) && !state.error_seen, "surrogate check pending outside a three-byte sequence")

  // The last byte of a message leaves the decoder state clear.
  `USV_ASSERT(a_clear_on_last, ctrl.advance && item.end_of_message |=> state == '0, "state not cleared after the last byte")

  // A byte that moves on is offered as a result in the next cycle.
  `USV_ASSERT(a_result_follows, ctrl.advance |=> result_stream.valid, "result lost after advance")

endmodule

// ----- design/usv_in_stage.sv -----
// Input register that holds one accepted byte item until it moves on.
module usv_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  usv_pkg::byte_item_t in_item,
  input  logic                advance,
  output logic                item_valid,
  output usv_pkg::byte_item_t item
);
  import usv_pkg::*;

  // The register takes a new item when empty or when its item moves on.
  assign in_ready = !item_valid || advance;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end
endmodule

// ----- design/usv_checker.sv -----
// Decoder state and the per-byte check that produces one result.
module usv_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  usv_pkg::stage_ctrl_t  ctrl,
  input  usv_pkg::byte_item_t   item,
  output usv_pkg::result_item_t result,
  output usv_pkg::check_state_t state
);
  import usv_pkg::*;

  check_state_t state_next;
  check_state_t checked;
  logic [7:0]   c;

  assign c = item.data_byte;

  // Apply one byte to the current state.
  always_comb begin
    checked = state;
    if (!state.error_seen) begin
      if (state.owed != OweNone) begin
        // A continuation is owed.
        if ((c & ContMask) != ContPattern) begin
          checked.error_seen = 1'b1;
        end else if (state.surrogate_check && ((c & SurrogateMask) == SurrogateMask)) begin
          checked.error_seen = 1'b1;
        end else begin
          checked.owed = state.owed - 2'd1;
        end
        checked.surrogate_check = 1'b0;
      end else if (c > AsciiMax) begin
        // A lead byte is expected.
        if ((c & Lead3Mask) == Lead2Pattern) begin
          checked.owed = OweOne;
        end else if ((c & Lead4Mask) == Lead3Pattern) begin
          checked.owed = OweTwo;
          checked.surrogate_check = (c == SurrogateLead);
        end else if ((c & Lead4TestMask) == Lead4Pattern) begin
          checked.owed = OweThree;
        end else begin
          checked.error_seen = 1'b1;
        end
      end
    end
  end

  // The result and the state for the next byte; the last byte clears the state.
  always_comb begin
    result.final_res = item.end_of_message;
    result.valid_res = !checked.error_seen
                       && (!item.end_of_message || (checked.owed == OweNone));
    state_next = item.end_of_message ? '0 : checked;
  end

  // State registers advance when the item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (ctrl.item_valid && ctrl.advance) begin
      state <= state_next;
    end
  end
endmodule

// ----- design/usv_out_stage.sv -----
// Result register that holds one result item until the receiver takes it.
module usv_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  usv_pkg::stage_ctrl_t  ctrl,
  input  usv_pkg::result_item_t result,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output usv_pkg::result_item_t out_item
);
  import usv_pkg::*;

  // Free when empty or when the held result is taken in this cycle.
  assign space = !out_valid || out_ready;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= ctrl.item_valid;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (ctrl.item_valid && ctrl.advance) begin
      out_item <= result;
    end
  end
endmodule
